// File: design/fat_directory_entry_scanner_assert.svh
// assertion macros shared by the scanner modules
// FDES_ASSERT is held off during reset, FDES_ASSERT_ALWAYS is checked at every edge
`ifndef FAT_DIRECTORY_ENTRY_SCANNER_ASSERT_SVH
`define FAT_DIRECTORY_ENTRY_SCANNER_ASSERT_SVH

`ifndef ASSERT_OFF
`define FDES_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);
`define FDES_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk_i) prop) else $error(msg);
`else
`define FDES_ASSERT(label, prop, msg)
`define FDES_ASSERT_ALWAYS(label, prop, msg)
`endif

`endif

// File: design/fdes_pkg.sv
`timescale 1ns / 1ps

package fdes_pkg;

  // directory entry markers
  localparam logic [7:0] DeletedMark  = 8'hE5;
  localparam logic [7:0] LfnAttr      = 8'h0F;
  localparam int unsigned VolumeIdBit  = 3;
  localparam int unsigned DirectoryBit = 4;
  localparam int unsigned HalfShift    = 16;
  localparam logic [5:0] LfnMax       = 6'd63;

  typedef enum logic {
    StatusFound = 1'b0,
    StatusEnd   = 1'b1
  } status_e;

  // one reduced directory entry
  typedef struct packed {
    logic [15:0] cluster_low_half;
    logic [15:0] cluster_high_half;
    logic [7:0]  attribute_bits;
    logic [7:0]  name_first_byte;
  } entry_t;

  // scan state carried from entry to entry
  typedef struct packed {
    logic [15:0] regular_count;
    logic [5:0]  long_name_count;
    logic        scan_done;
  } scan_state_t;

  // one report
  typedef struct packed {
    status_e     status;
    logic [31:0] cluster_number;
    logic        is_directory;
    logic [5:0]  long_name_entries;
  } result_t;

endpackage

// File: design/fdes_entry_eval.sv
`timescale 1ns / 1ps

module fdes_entry_eval (
  input  logic                first_i,
  input  fdes_pkg::entry_t    entry_i,
  input  fdes_pkg::scan_state_t state_i,
  input  logic [15:0]         target_index_i,
  output fdes_pkg::scan_state_t state_o,
  output logic                res_valid_o,
  output fdes_pkg::result_t   result_o
);
  import fdes_pkg::*;

  scan_state_t base;

  // a first-of-directory word starts from cleared counters
  always_comb begin
    if (first_i) begin
      base = '0;
    end else begin
      base = state_i;
    end
  end

  // classify the entry in priority order
  always_comb begin
    state_o     = base;
    res_valid_o = 1'b0;
    result_o    = '{status: StatusFound, cluster_number: '0,
                    is_directory: 1'b0, long_name_entries: '0};
    priority if (base.scan_done) begin
      // ignored until the next directory starts
    end else if (entry_i.name_first_byte == 8'h00) begin
      res_valid_o     = 1'b1;
      result_o.status = StatusEnd;
      state_o.scan_done = 1'b1;
    end else if (entry_i.name_first_byte == DeletedMark) begin
      state_o.long_name_count = '0;
    end else if (entry_i.attribute_bits == LfnAttr) begin
      if (base.long_name_count != LfnMax) begin
        state_o.long_name_count = base.long_name_count + 6'd1;
      end
    end else if (entry_i.attribute_bits[VolumeIdBit]) begin
      state_o.long_name_count = '0;
    end else if (base.regular_count == target_index_i) begin
      res_valid_o                = 1'b1;
      result_o.status            = StatusFound;
      result_o.cluster_number    = {entry_i.cluster_high_half, entry_i.cluster_low_half};
      result_o.is_directory      = entry_i.attribute_bits[DirectoryBit];
      result_o.long_name_entries = base.long_name_count;
      state_o.scan_done          = 1'b1;
    end else begin
      state_o.regular_count   = base.regular_count + 16'd1;
      state_o.long_name_count = '0;
    end
  end

endmodule

// File: design/fdes_out_reg.sv
`timescale 1ns / 1ps

`include "fat_directory_entry_scanner_assert.svh"

module fdes_out_reg (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              load_i,
  input  fdes_pkg::result_t result_i,
  input  logic              ready_i,
  output logic              free_o,
  output logic              valid_o,
  output fdes_pkg::result_t result_o
);
  import fdes_pkg::*;

  logic    valid_q, valid_d;
  result_t result_q;

  // slot is free when it is empty or when the held word is taken this cycle
  assign free_o = !valid_q || ready_i;

  always_comb begin
    valid_d = valid_q;
    if (load_i) begin
      valid_d = 1'b1;
    end else if (ready_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      result_q <= result_i;
    end
  end

  assign valid_o  = valid_q;
  assign result_o = result_q;

  // never load over a word that is still waiting
  `FDES_ASSERT(a_no_overwrite, load_i |-> free_o, "result loaded over a pending word")

endmodule

// File: design/fat_directory_entry_scanner.sv
`timescale 1ns / 1ps

// FAT directory entry scanner: takes one reduced directory entry per cycle and reports the
// entry whose regular index matches target_index (cluster, directory flag, preceding
// long-name count) or end of directory on a zero first byte. An entry is held in the input
// register, is classified against the counters and lands in the output register, from which
// its report is offered; the sustained rate is one entry per cycle, and it drops only
// while a report waits on m_axis_tready. Entries after a report are dropped until one
// with tuser set.
`include "fat_directory_entry_scanner_assert.svh"

module fat_directory_entry_scanner (
  input  logic        clk_i,
  input  logic        rst_ni,
  // configuration: target_index
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [15:0] cfg_data_i,
  // entry stream
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // name_first_byte, attribute_bits, cluster_high_half, cluster_low_half
  input  logic [47:0] s_axis_tdata,
  // first_of_directory
  input  logic        s_axis_tuser,
  // result stream
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // cluster_number, is_directory, long_name_entries, one zero pad bit
  output logic [39:0] m_axis_tdata,
  // status
  output logic        m_axis_tuser
);
  import fdes_pkg::*;

  logic        in_valid_q, in_valid_d;
  logic        first_q;
  entry_t      entry_q;
  logic [15:0] target_q;
  scan_state_t state_q, state_d;
  logic        res_valid;
  result_t     res;
  logic        out_free;
  logic        stage_fire;
  logic        out_valid;
  result_t     out_res;

  // configuration register
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      target_q <= '0;
    end else if (cfg_valid_i) begin
      target_q <= cfg_data_i;
    end
  end

  // entry leaves the input register unless its report has nowhere to go
  assign stage_fire    = in_valid_q && (!res_valid || out_free);
  assign s_axis_tready = !in_valid_q || stage_fire;

  always_comb begin
    in_valid_d = in_valid_q;
    if (s_axis_tready) begin
      in_valid_d = s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else begin
      in_valid_q <= in_valid_d;
    end
  end

  // input register payload
  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid && s_axis_tready) begin
      first_q                   <= s_axis_tuser;
      entry_q.name_first_byte   <= s_axis_tdata[7:0];
      entry_q.attribute_bits    <= s_axis_tdata[15:8];
      entry_q.cluster_high_half <= s_axis_tdata[31:16];
      entry_q.cluster_low_half  <= s_axis_tdata[47:32];
    end
  end

  fdes_entry_eval u_eval (
    .first_i        (first_q),
    .entry_i        (entry_q),
    .state_i        (state_q),
    .target_index_i (target_q),
    .state_o        (state_d),
    .res_valid_o    (res_valid),
    .result_o       (res)
  );

  // scan counters
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= '0;
    end else if (stage_fire) begin
      state_q <= state_d;
    end
  end

  fdes_out_reg u_out (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .load_i   (stage_fire && res_valid),
    .result_i (res),
    .ready_i  (m_axis_tready),
    .free_o   (out_free),
    .valid_o  (out_valid),
    .result_o (out_res)
  );

  // result word packing
  assign m_axis_tvalid = out_valid;
  assign m_axis_tuser  = out_res.status;
  assign m_axis_tdata  = {1'b0, out_res.long_name_entries, out_res.is_directory,
                          out_res.cluster_number};

  // a report always closes the scan
  `FDES_ASSERT(a_report_sets_done, stage_fire && res_valid |=> state_q.scan_done,
               "report did not set scan done")
  // a closed scan stays silent until a new directory
  `FDES_ASSERT(a_done_silent, in_valid_q && state_q.scan_done && !first_q |-> !res_valid,
               "result produced after scan done")
  // end-of-directory reports carry an empty payload
  `FDES_ASSERT(a_end_empty, m_axis_tvalid && m_axis_tuser == StatusEnd |->
               m_axis_tdata == 40'd0, "not-found report with payload")
  // the input side only stalls on a held entry
  `FDES_ASSERT_ALWAYS(a_stall_held, !s_axis_tready |-> in_valid_q,
                      "input stalled with empty register")

endmodule

// File: verif/tb_fat_directory_entry_scanner.sv
`timescale 1ns / 1ps

module tb_fat_directory_entry_scanner;
  import fdes_pkg::*;

  // kinds of entries the stimulus builds directories from
  typedef enum {
    KindRegular,
    KindLfn,
    KindDeleted,
    KindVolume,
    KindEnd,
    KindAny
  } entry_kind_e;

  // predicts reports from accepted entries and checks the ones that come out
  class dir_scan_scoreboard;
    logic [15:0] target_index;
    logic [15:0] regular_count;
    logic [5:0]  long_name_count;
    bit          scan_done;
    result_t     expected_reports[$];
    int unsigned errors;

    function new();
      target_index    = '0;
      regular_count   = '0;
      long_name_count = '0;
      scan_done       = 1'b0;
      errors          = 0;
    endfunction

    function void set_target(logic [15:0] value);
      target_index = value;
    endfunction

    function int pending();
      return expected_reports.size();
    endfunction

    function void note_entry(logic first, entry_t e);
      result_t rep;
      if (first) begin
        regular_count   = '0;
        long_name_count = '0;
        scan_done       = 1'b0;
      end
      if (scan_done) return;
      // classification in priority order
      if (e.name_first_byte == 8'h00) begin
        rep.status            = StatusEnd;
        rep.cluster_number    = '0;
        rep.is_directory      = 1'b0;
        rep.long_name_entries = '0;
        expected_reports.push_back(rep);
        scan_done = 1'b1;
      end else if (e.name_first_byte == DeletedMark) begin
        long_name_count = '0;
      end else if (e.attribute_bits == LfnAttr) begin
        if (long_name_count < LfnMax) long_name_count++;
      end else if (e.attribute_bits[VolumeIdBit]) begin
        long_name_count = '0;
      end else if (regular_count == target_index) begin
        rep.status            = StatusFound;
        rep.cluster_number    = ({16'h0000, e.cluster_high_half} << HalfShift)
                                | {16'h0000, e.cluster_low_half};
        rep.is_directory      = e.attribute_bits[DirectoryBit];
        rep.long_name_entries = long_name_count;
        expected_reports.push_back(rep);
        scan_done = 1'b1;
      end else begin
        regular_count   = regular_count + 16'd1;
        long_name_count = '0;
      end
    endfunction

    function void check_result(result_t got);
      result_t exp;
      if (expected_reports.size() == 0) begin
        $error("unexpected report: status %0d cluster_number %0h", got.status,
               got.cluster_number);
        errors++;
        return;
      end
      exp = expected_reports.pop_front();
      if (exp.status !== got.status) begin
        $error("status: expected %0d actual %0d", exp.status, got.status);
        errors++;
      end
      if (exp.cluster_number !== got.cluster_number) begin
        $error("cluster_number: expected %0h actual %0h", exp.cluster_number,
               got.cluster_number);
        errors++;
      end
      if (exp.is_directory !== got.is_directory) begin
        $error("is_directory: expected %0d actual %0d", exp.is_directory, got.is_directory);
        errors++;
      end
      if (exp.long_name_entries !== got.long_name_entries) begin
        $error("long_name_entries: expected %0d actual %0d", exp.long_name_entries,
               got.long_name_entries);
        errors++;
      end
    endfunction
  endclass

  logic        clk_i         = 1'b0;
  logic        rst_ni        = 1'b0;
  logic        cfg_valid_i   = 1'b0;
  logic        cfg_ready_o;
  logic [15:0] cfg_data_i    = '0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [47:0] s_axis_tdata  = '0;
  logic        s_axis_tuser  = 1'b0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [39:0] m_axis_tdata;
  logic        m_axis_tuser;

  dir_scan_scoreboard sb;
  int unsigned items_sent  = 0;
  bit          tx_idle_on  = 1'b1;
  bit          rx_idle_on  = 1'b1;
  int          hold_cycles = 0;

  fat_directory_entry_scanner dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_data_i    (cfg_data_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  // 10 ns clock
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // report monitor
  always @(posedge clk_i) begin
    result_t got;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got.status            = status_e'(m_axis_tuser);
      got.cluster_number    = m_axis_tdata[31:0];
      got.is_directory      = m_axis_tdata[32];
      got.long_name_entries = m_axis_tdata[38:33];
      sb.check_result(got);
    end
  end

  // report sink with random stalls and an occasional long hold-off
  initial begin : result_sink
    int stall_left;
    stall_left = 0;
    forever begin
      @(posedge clk_i);
      if (hold_cycles != 0) begin
        stall_left  = hold_cycles;
        hold_cycles = 0;
      end
      if (stall_left == 0 && rx_idle_on && $urandom_range(0, 5) == 0)
        stall_left = $urandom_range(1, 12);
      if (stall_left != 0) begin
        m_axis_tready <= 1'b0;
        stall_left--;
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  // offer one entry, wait for it to be taken, then maybe leave a gap
  task automatic send_entry(input logic first, input logic [7:0] name,
                            input logic [7:0] attr, input logic [15:0] hi,
                            input logic [15:0] lo);
    entry_t e;
    e.name_first_byte   = name;
    e.attribute_bits    = attr;
    e.cluster_high_half = hi;
    e.cluster_low_half  = lo;
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= e;
    s_axis_tuser  <= first;
    do @(posedge clk_i); while (!s_axis_tready);
    sb.note_entry(first, e);
    items_sent++;
    if (tx_idle_on && $urandom_range(0, 4) == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk_i);
    end
  endtask

  // random entry of the given kind
  task automatic send_kind(input logic first, input entry_kind_e kind);
    logic [7:0] name;
    logic [7:0] attr;
    name = 8'($urandom_range(1, 255));
    attr = 8'($urandom_range(0, 255));
    case (kind)
      KindRegular: begin
        if (name == DeletedMark) name = 8'h2E;
        attr[VolumeIdBit] = 1'b0;
      end
      KindLfn: begin
        if (name == DeletedMark) name = 8'h41;
        attr = LfnAttr;
      end
      KindDeleted: name = DeletedMark;
      KindVolume: begin
        if (name == DeletedMark) name = 8'h56;
        attr[VolumeIdBit] = 1'b1;
        if (attr == LfnAttr) attr = 8'h08;
      end
      KindEnd: name = 8'h00;
      default: name = 8'($urandom_range(0, 255));
    endcase
    send_entry(first, name, attr, 16'($urandom_range(0, 65535)),
               16'($urandom_range(0, 65535)));
  endtask

  function automatic entry_kind_e pick_kind();
    int r;
    r = $urandom_range(0, 99);
    if (r < 42) return KindRegular;
    if (r < 70) return KindLfn;
    if (r < 80) return KindDeleted;
    if (r < 88) return KindVolume;
    if (r < 97) return KindAny;
    return KindEnd;
  endfunction

  // one directory: first entry flagged, optional long-name run, optional end marker
  task automatic send_directory(input int slots, input bit long_run, input bit terminate);
    entry_kind_e kind;
    logic        first;
    int          run;
    first = 1'b1;
    for (int i = 0; i < slots; i++) begin
      kind = pick_kind();
      run  = 1;
      if (kind == KindLfn && long_run) begin
        run      = $urandom_range(60, 70);
        long_run = 1'b0;
      end
      for (int j = 0; j < run; j++) begin
        send_kind(first, kind);
        first = 1'b0;
      end
    end
    if (terminate) send_kind(first, KindEnd);
  endtask

  // stop offering and let every report and any in-flight entry settle
  task automatic drain();
    s_axis_tvalid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (6) @(posedge clk_i);
  endtask

  task automatic write_target(input logic [15:0] value);
    drain();
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= value;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    sb.set_target(value);
  endtask

  // one setting of target_index with a mix of directories and noise
  task automatic run_phase(input logic [15:0] target, input bit idle, input int quota);
    int unsigned start;
    int          slots;
    write_target(target);
    tx_idle_on = idle;
    rx_idle_on = idle;
    start      = items_sent;
    while (items_sent - start < quota) begin
      if ($urandom_range(0, 99) < 12) begin
        repeat ($urandom_range(1, 6)) send_kind($urandom_range(0, 9) == 0, KindAny);
      end else begin
        if (target > 64) slots = $urandom_range(1, 12);
        else slots = 2 * target + $urandom_range(1, 10);
        send_directory(slots, target < 16 && $urandom_range(0, 9) == 0,
                       $urandom_range(0, 4) != 0);
      end
    end
  endtask

  initial begin
    sb = new();
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: entries before any directory start, ignoring after a report
    send_entry(1'b0, 8'h41, 8'h00, 16'hFFFF, 16'h0000);
    send_entry(1'b0, 8'h00, 8'hFF, 16'hFFFF, 16'hFFFF);
    send_entry(1'b0, 8'h41, 8'h10, 16'h0001, 16'h0001);
    // long-name counting cleared by deleted and volume-id entries
    send_entry(1'b1, 8'hFF, LfnAttr, 16'h0000, 16'h0000);
    send_entry(1'b0, 8'h01, LfnAttr, 16'hFFFF, 16'hFFFF);
    send_entry(1'b0, DeletedMark, LfnAttr, 16'h1111, 16'h2222);
    send_entry(1'b0, 8'h42, LfnAttr, 16'h3333, 16'h4444);
    send_entry(1'b0, 8'h20, 8'h08, 16'h5555, 16'h6666);
    send_entry(1'b0, 8'h43, LfnAttr, 16'h7777, 16'h8888);
    send_entry(1'b0, 8'h44, LfnAttr, 16'h9999, 16'hAAAA);
    send_entry(1'b0, 8'hFF, 8'hF7, 16'h0000, 16'hFFFF);
    // end of directory on the first entry
    send_entry(1'b1, 8'h00, 8'hFF, 16'hFFFF, 16'hFFFF);
    send_entry(1'b1, DeletedMark, 8'h00, 16'h0000, 16'h0000);
    send_entry(1'b0, 8'h7F, 8'hE7, 16'hFFFF, 16'hFFFF);
    // nonzero target
    write_target(16'd2);
    send_entry(1'b1, 8'h80, 8'h00, 16'h1234, 16'h5678);
    send_entry(1'b0, 8'hAA, 8'h10, 16'hFEDC, 16'hBA98);
    send_entry(1'b0, 8'h55, LfnAttr, 16'h0F0F, 16'hF0F0);
    send_entry(1'b0, 8'h2E, 8'h10, 16'h8000, 16'h0001);
    send_entry(1'b0, 8'h00, 8'h00, 16'h0000, 16'h0000);
    send_entry(1'b1, 8'h00, 8'h10, 16'hFFFF, 16'h0000);

    run_phase(16'd0, 1'b1, 70);
    run_phase(16'hFFFF, 1'b1, 50);

    // receiver holds off while entries keep coming, so the block backs up
    write_target(16'd0);
    tx_idle_on  = 1'b0;
    rx_idle_on  = 1'b0;
    hold_cycles = 250;
    repeat (6) send_directory($urandom_range(2, 6), 1'b0, 1'b1);
    drain();

    repeat (6) run_phase(16'($urandom_range(0, 7)), 1'($urandom_range(0, 1)), 70);
    run_phase(16'($urandom_range(0, 65535)), 1'b1, 50);
    run_phase(16'd1, 1'b0, 70);

    drain();
    repeat (10) @(posedge clk_i);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  // overall time limit
  initial begin
    #5_000_000;
    $display("Some tests failed");
    $finish;
  end

endmodule

// File: files.f
+incdir+design
design/fdes_pkg.sv
design/fdes_entry_eval.sv
design/fdes_out_reg.sv
design/fat_directory_entry_scanner.sv
verif/tb_fat_directory_entry_scanner.sv
